FILE: hdl/cpu8_pkg.sv
// Shared constants, types and index helpers for the 8-bit execute stage.
package cpu8_pkg;

  localparam int NUM_REGS  = 64;
  localparam int MEM_BYTES = 256;
  localparam int RIDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MADDR_W   = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  localparam logic [3:0] OP_ADD   = 4'h0;
  localparam logic [3:0] OP_SUB   = 4'h1;
  localparam logic [3:0] OP_MUL   = 4'h2;
  localparam logic [3:0] OP_AND   = 4'h3;
  localparam logic [3:0] OP_OR    = 4'h4;
  localparam logic [3:0] OP_ROTL  = 4'h5;
  localparam logic [3:0] OP_ROTR  = 4'h6;
  localparam logic [3:0] OP_LOAD  = 4'h7;
  localparam logic [3:0] OP_STORE = 4'h8;
  localparam logic [3:0] OP_BEQZ  = 4'h9;
  localparam logic [3:0] OP_JR    = 4'hA;
  localparam logic [3:0] OP_MOVI  = 4'hB;

  typedef logic [RIDX_W-1:0]  ridx_t;
  typedef logic [MADDR_W-1:0] maddr_t;

  typedef struct packed {
    logic [3:0]  opcode;
    ridx_t       ra;
    logic [7:0]  operand;
    logic [15:0] instr_pc;
  } instr_t;

  typedef struct packed {
    logic        redirect;
    logic [15:0] target_pc;
    logic        reg_written;
    logic [5:0]  written_index;
    logic [7:0]  written_value;
  } res_t;

  typedef struct packed {
    logic       en;
    maddr_t     addr;
    logic [7:0] data;
  } store_req_t;

  // Register counts and memory sizes are powers of two: reduce by masking.
  function automatic ridx_t reg_idx(input logic [7:0] v);
    reg_idx = v[RIDX_W-1:0];
  endfunction

  function automatic maddr_t mem_addr(input logic [7:0] v);
    mem_addr = v[MADDR_W-1:0];
  endfunction

endpackage

FILE: hdl/cpu8_regfile.sv
// Register file: two synchronous read ports, one write port, valid bits, bypass.
module cpu8_regfile import cpu8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rd_en,
  input  ridx_t      rd_addr_a,
  input  ridx_t      rd_addr_b,
  output logic [7:0] rd_data_a,
  output logic [7:0] rd_data_b,
  input  logic       wr_en,
  input  ridx_t      wr_addr,
  input  logic [7:0] wr_data
);

  logic [7:0]          mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [7:0]          q_a, q_b, fwd_data;
  logic                vld_a, vld_b, fwd_a, fwd_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_a <= mem[rd_addr_a];
      q_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a <= vld[rd_addr_a];
        vld_b <= vld[rd_addr_b];
        fwd_a <= wr_en && (wr_addr == rd_addr_a);
        fwd_b <= wr_en && (wr_addr == rd_addr_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // Same-edge write wins over the stale array read; unwritten entries read zero.
  assign rd_data_a = fwd_a ? fwd_data : (vld_a ? q_a : 8'h00);
  assign rd_data_b = fwd_b ? fwd_data : (vld_b ? q_b : 8'h00);

endmodule

FILE: hdl/cpu8_dmem.sv
// Byte data memory: one synchronous read port, one write port, valid bits, bypass.
module cpu8_dmem import cpu8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rd_en,
  input  maddr_t     rd_addr,
  output logic [7:0] rd_data,
  input  store_req_t wr
);

  logic [7:0]           mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] vld;
  logic [7:0]           q, fwd_data;
  logic                 vld_q, fwd;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q        <= mem[rd_addr];
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      fwd   <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
        fwd   <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd ? fwd_data : (vld_q ? q : 8'h00);

endmodule

FILE: hdl/cpu8_alu.sv
// Execute datapath: computes the result and the store request of one instruction.
module cpu8_alu import cpu8_pkg::*; (
  input  instr_t     instr,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] load_data,
  output res_t       res,
  output store_req_t store
);

  logic [15:0] prod;
  logic [2:0]  rl_amt, rr_amt;
  logic [15:0] rl_dbl, rr_dbl;
  logic [15:0] br_target;
  logic [7:0]  ra_ext;

  assign prod      = a * b;
  assign rl_amt    = instr.operand[2:0];
  assign rr_amt    = 3'd0 - rl_amt;
  assign rl_dbl    = {a, a} << rl_amt;
  assign rr_dbl    = {a, a} << rr_amt;
  assign br_target = instr.instr_pc + 16'd1 + {{8{instr.operand[7]}}, instr.operand};
  assign ra_ext    = 8'(instr.ra);

  always_comb begin
    res        = '0;
    store.en   = 1'b0;
    store.addr = mem_addr(instr.operand);
    store.data = a;
    case (instr.opcode)
      OP_ADD:  begin res.written_value = a + b;         res.reg_written = 1'b1; end
      OP_SUB:  begin res.written_value = a - b;         res.reg_written = 1'b1; end
      OP_MUL:  begin res.written_value = prod[7:0];     res.reg_written = 1'b1; end
      OP_AND:  begin res.written_value = a & b;         res.reg_written = 1'b1; end
      OP_OR:   begin res.written_value = a | b;         res.reg_written = 1'b1; end
      OP_ROTL: begin res.written_value = rl_dbl[15:8];  res.reg_written = 1'b1; end
      OP_ROTR: begin res.written_value = rr_dbl[15:8];  res.reg_written = 1'b1; end
      OP_LOAD: begin res.written_value = load_data;     res.reg_written = 1'b1; end
      OP_MOVI: begin res.written_value = instr.operand; res.reg_written = 1'b1; end
      OP_STORE: begin
        res.written_value = a;
        store.en          = 1'b1;
      end
      OP_BEQZ: begin
        if (a == 8'h00) begin
          res.redirect  = 1'b1;
          res.target_pc = br_target;
        end
      end
      OP_JR: begin
        res.redirect  = 1'b1;
        res.target_pc = {a, b};
      end
      default: begin
      end
    endcase
    if (res.reg_written) begin
      res.written_index = ra_ext[5:0];
    end
  end

endmodule

FILE: hdl/cpu8_execute_stage_unit.sv
// Top level of the 8-bit execute stage: read stage, execute/write-back stage, output register.
// The read edge registers the operand reads; the execute edge registers the output register.
// Throughput: one instruction per cycle unless out_ready stalls, set by the single write port
//   of each store; results of one are visible to the very next via read-port bypass.
// Reset: synchronous, clears the pipeline valids and the per-entry valid bits of the
//   register file and data memory; unwritten entries read as zero, no clearing pass.
module cpu8_execute_stage_unit import cpu8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // instruction channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [5:0]  first_reg,
  input  logic [7:0]  operand,
  input  logic [15:0] instr_pc,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        redirect,
  output logic [15:0] target_pc,
  output logic        reg_written,
  output logic [5:0]  written_index,
  output logic [7:0]  written_value
);

  // Stage 1 holds the instruction whose operands are being read out of the stores.
  logic       s1_valid;
  instr_t     s1_instr;
  logic       s1_fire;
  logic       in_fire;

  logic [7:0] rd_a, rd_b, ld_data;
  res_t       s1_res;
  store_req_t s1_store;
  store_req_t dm_wr;
  res_t       out_res;

  ridx_t      in_ra, in_rb;

  // Stage 1 retires into the output register whenever that register is free or draining.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  // A new transaction is taken when stage 1 is empty or empties in the same cycle.
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign in_ra = reg_idx(8'(first_reg));
  assign in_rb = reg_idx(operand);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr.opcode   <= opcode;
      s1_instr.ra       <= in_ra;
      s1_instr.operand  <= operand;
      s1_instr.instr_pc <= instr_pc;
    end
  end

  // Reads are issued at the accept edge; writes of the retiring instruction land on
  // the same edge and are bypassed inside the store modules.
  cpu8_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_addr_a (in_ra),
    .rd_addr_b (in_rb),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (s1_fire && s1_res.reg_written),
    .wr_addr   (s1_instr.ra),
    .wr_data   (s1_res.written_value)
  );

  assign dm_wr.en   = s1_fire && s1_store.en;
  assign dm_wr.addr = s1_store.addr;
  assign dm_wr.data = s1_store.data;

  cpu8_dmem u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (mem_addr(operand)),
    .rd_data (ld_data),
    .wr      (dm_wr)
  );

  cpu8_alu u_alu (
    .instr     (s1_instr),
    .a         (rd_a),
    .b         (rd_b),
    .load_data (ld_data),
    .res       (s1_res),
    .store     (s1_store)
  );

  // Output register: holds a finished transaction until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= s1_res;
    end
  end

  assign redirect      = out_res.redirect;
  assign target_pc     = out_res.target_pc;
  assign reg_written   = out_res.reg_written;
  assign written_index = out_res.written_index;
  assign written_value = out_res.written_value;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the 8-bit execute stage: directed corners plus random programs.
`timescale 1ns / 1ps

module tb;
  import cpu8_pkg::*;

  // Opcodes 12..15 have no name in the package; they must be no-ops.
  localparam logic [3:0] OP_UNUSED_FIRST = 4'hC;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'hF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;   // margin for the pipe to drain

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = '0;
  logic [5:0]  first_reg = '0;
  logic [7:0]  operand = '0;
  logic [15:0] instr_pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        redirect;
  logic [15:0] target_pc;
  logic        reg_written;
  logic [5:0]  written_index;
  logic [7:0]  written_value;

  // Shadow architectural state, updated as each transaction is accepted.
  logic [7:0] gpr  [NUM_REGS];
  logic [7:0] dmem [MEM_BYTES];
  res_t       pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int redirect_count = 0;
  int cycle_count    = 0;

  cpu8_execute_stage_unit DUT (.*);

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Random backpressure on the result channel.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cpu8_execute_stage_unit verification failed");
      $finish;
    end
  end

  // Executes one instruction on the shadow state and returns what the stage
  // should report for it.
  function automatic res_t exec_instr(input logic [3:0] op, input logic [5:0] dst,
                                      input logic [7:0] opnd, input logic [15:0] pc);
    int unsigned ra;
    int unsigned rb;
    int unsigned addr;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] dbl;
    logic [7:0]  value;
    logic        wrote;
    res_t        r;
    ra    = dst % NUM_REGS;
    rb    = opnd % NUM_REGS;
    addr  = opnd % MEM_BYTES;
    a     = gpr[ra];
    b     = gpr[rb];
    dbl   = {a, a};
    value = '0;
    wrote = 1'b0;
    r     = '0;
    case (op)
      OP_ADD: begin value = a + b; wrote = 1'b1; end
      OP_SUB: begin value = a - b; wrote = 1'b1; end
      OP_MUL: begin value = 8'(a * b); wrote = 1'b1; end
      OP_AND: begin value = a & b; wrote = 1'b1; end
      OP_OR:  begin value = a | b; wrote = 1'b1; end
      OP_ROTL: begin
        dbl   = dbl << opnd[2:0];
        value = dbl[15:8];
        wrote = 1'b1;
      end
      OP_ROTR: begin
        dbl   = dbl >> opnd[2:0];
        value = dbl[7:0];
        wrote = 1'b1;
      end
      OP_LOAD: begin value = dmem[addr]; wrote = 1'b1; end
      OP_STORE: begin
        dmem[addr] = a;
        value      = a;
      end
      OP_BEQZ: begin
        if (a == 8'h00) begin
          r.redirect  = 1'b1;
          r.target_pc = pc + 16'd1 + {{8{opnd[7]}}, opnd};
        end
      end
      OP_JR: begin
        r.redirect  = 1'b1;
        r.target_pc = {a, b};
      end
      OP_MOVI: begin value = opnd; wrote = 1'b1; end
      default: ;
    endcase
    if (wrote) begin
      gpr[ra]         = value;
      r.reg_written   = 1'b1;
      r.written_index = 6'(ra);
    end
    r.written_value = value;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ERROR %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Scoreboard: predict on every accepted instruction, compare every accepted
  // result against the oldest prediction. Prediction goes first so ordering
  // holds even if a result shared an edge with its own instruction.
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_results.push_back(exec_instr(opcode, first_reg, operand, instr_pc));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ERROR unexpected result transaction (redirect=%0b target=0x%0h)",
                   $time, redirect, target_pc);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("redirect", want.redirect, redirect);
          check_field("target_pc", want.target_pc, target_pc);
          check_field("reg_written", want.reg_written, reg_written);
          check_field("written_index", want.written_index, written_index);
          check_field("written_value", want.written_value, written_value);
          checked_count++;
          if (redirect)
            redirect_count++;
        end
      end
    end
  end

  // Presents one instruction after an optional random gap and holds it until
  // the stage takes it.
  task automatic send_instr(input logic [3:0] op, input logic [5:0] dst,
                            input logic [7:0] opnd, input logic [15:0] pc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    first_reg <= dst;
    operand   <= opnd;
    instr_pc  <= pc;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sent_count++;
  endtask

  // Field extremes, every opcode, wraparound, register/address reduction,
  // reads of never-written memory, branch taken/not taken, no-op opcodes.
  task automatic test_corner_cases();
    logic [3:0] op;
    send_instr(OP_MOVI, 6'd63, 8'hFF, 16'h0000);
    send_instr(OP_MOVI, 6'd0, 8'h01, 16'hFFFF);
    send_instr(OP_ADD, 6'd63, 8'h40, 16'h0001);   // operand 0x40 names r0; sum wraps to 0
    send_instr(OP_SUB, 6'd63, 8'h00, 16'h0002);   // 0 - 1 borrows to 0xFF
    send_instr(OP_MUL, 6'd63, 8'h3F, 16'h0003);   // 0xFF * 0xFF keeps low byte
    send_instr(OP_MOVI, 6'd1, 8'hA5, 16'h0004);
    send_instr(OP_AND, 6'd1, 8'h80, 16'h0005);    // 0x80 reduces to r0
    send_instr(OP_OR, 6'd1, 8'hFF, 16'h0006);     // 0xFF reduces to r63
    send_instr(OP_ROTL, 6'd1, 8'h00, 16'h0007);   // zero amount: unchanged
    send_instr(OP_ROTL, 6'd1, 8'hFF, 16'h0008);   // amount 7
    send_instr(OP_ROTR, 6'd1, 8'h09, 16'h0009);   // amount wraps to 1
    send_instr(OP_STORE, 6'd1, 8'hFF, 16'h000A);
    send_instr(OP_LOAD, 6'd2, 8'hFF, 16'h000B);   // reads back the store just done
    send_instr(OP_LOAD, 6'd3, 8'h00, 16'h000C);   // never written: reset zero
    send_instr(OP_STORE, 6'd0, 8'h00, 16'h000D);
    send_instr(OP_BEQZ, 6'd4, 8'h80, 16'h0000);   // taken, most negative offset, wraps low
    send_instr(OP_BEQZ, 6'd4, 8'h7F, 16'hFFFF);   // taken, wraps high
    send_instr(OP_BEQZ, 6'd1, 8'h10, 16'h1234);   // not taken
    send_instr(OP_JR, 6'd63, 8'h41, 16'h5678);    // target from r63:r1
    for (op = OP_UNUSED_FIRST; op != OP_UNUSED_FIRST - 4'd1; op++) begin
      send_instr(op, 6'($urandom_range(63)), 8'($urandom_range(255)),
                 16'($urandom_range(65535)));
      if (op == OP_UNUSED_LAST)
        break;
    end
    send_instr(OP_MOVI, 6'd63, 8'h00, 16'hFFFF);
  endtask

  function automatic logic [3:0] pick_opcode();
    if ($urandom_range(15) == 0)
      return 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    return 4'($urandom_range(OP_MOVI));
  endfunction

  // Random instructions. With a narrow pool, registers and addresses collide
  // constantly so back-to-back dependencies and store/load pairs are common.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input bit narrow);
    logic [3:0] op;
    logic [5:0] dst;
    logic [7:0] opnd;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      op   = pick_opcode();
      dst  = 6'($urandom_range(63));
      opnd = 8'($urandom_range(255));
      if (narrow) begin
        dst[5:3]  = 3'b000;
        opnd[5:3] = 3'b000;
      end
      // zero registers keep BEQZ taken often enough
      if (op == OP_MOVI && $urandom_range(3) == 0)
        opnd = 8'h00;
      send_instr(op, dst, opnd, 16'($urandom_range(65535)));
    end
  endtask

  task automatic test_dependent_chains();
    test_random_traffic(150, 0, 0, 1'b1);
    test_random_traffic(150, 19, 19, 1'b1);
  endtask

  task automatic test_idle_mixes();
    test_random_traffic(235, 0, 0, 1'b0);
    test_random_traffic(235, 61, 0, 1'b0);
    test_random_traffic(235, 0, 61, 1'b0);
    test_random_traffic(235, 19, 19, 1'b0);
  endtask

  initial begin
    foreach (gpr[i])
      gpr[i] = '0;
    foreach (dmem[i])
      dmem[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();
    test_dependent_chains();
    test_idle_mixes();

    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions: directed corners, dependency chains, four idle mixes.",
             sent_count);
    $display("Checked %0d results, %0d of them redirects; %0d mismatches.",
             checked_count, redirect_count, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("cpu8_execute_stage_unit verification clean");
    end else begin
      $display("cpu8_execute_stage_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cpu8_pkg.sv
hdl/cpu8_regfile.sv
hdl/cpu8_dmem.sv
hdl/cpu8_alu.sv
hdl/cpu8_execute_stage_unit.sv
tb/tb.sv
